// ----- rtl/eic_pkg.sv -----
package eic_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PAIR_A = 3'd0;
  localparam logic [2:0] CFG_PAIR_B = 3'd1;
  localparam logic [2:0] CFG_PAIR_C = 3'd2;
  localparam logic [2:0] CFG_PAIR_D = 3'd3;
  localparam logic [2:0] CFG_FINAL  = 3'd4;
  localparam logic [2:0] CFG_LIMIT  = 3'd5;

  localparam logic [31:0] ERR_SAT = 32'hFFFF_FFFF;

  // One point correspondence as it travels from front to back
  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [23:0] x2;
    logic signed [23:0] y2;
    logic               start;
  } item_t;

  // Fundamental matrix, entries 0..8, row major, signed Q1.30
  typedef logic [8:0][31:0] coef_t;

endpackage

// ----- rtl/eic_queue.sv -----
module eic_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [23:0]    first_x_i,
  input  logic signed [23:0]    first_y_i,
  input  logic signed [23:0]    second_x_i,
  input  logic signed [23:0]    second_y_i,
  input  logic                  start_set_i,
  output logic                  item_valid_o,
  output eic_pkg::item_t        item_o,
  input  logic                  item_pop_i
);
  import eic_pkg::*;

  item_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = ent_q[rp_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= '{x1: first_x_i, y1: first_y_i, x2: second_x_i, y2: second_y_i,
                       start: start_set_i};
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- rtl/eic_engine.sv -----
module eic_engine #(
  parameter int MAX_POINTS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  eic_pkg::item_t  item_i,
  output logic            item_pop_o,
  input  eic_pkg::coef_t  coef_i,
  input  logic [23:0]     limit_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     error_o,
  output logic            inlier_o,
  output logic [16:0]     good_count_o
);
  import eic_pkg::*;

  localparam int CAP = (MAX_POINTS > 131071) ? 131071 : MAX_POINTS;

  // Micro-op indexes of the shared multiplier
  localparam logic [4:0] OP_ROW0     = 5'd0;
  localparam logic [4:0] OP_ROW_LAST = 5'd5;
  localparam logic [4:0] OP_NA       = 5'd6;
  localparam logic [4:0] OP_NB       = 5'd7;
  localparam logic [4:0] OP_DX       = 5'd8;
  localparam logic [4:0] OP_DY       = 5'd9;
  localparam logic [4:0] OP_SQ0      = 5'd10;
  localparam logic [4:0] OP_SQ1      = 5'd11;
  localparam logic [4:0] OP_SQ2      = 5'd12;
  localparam logic [4:0] OP_TT       = 5'd13;
  localparam logic [4:0] OP_L0       = 5'd14;
  localparam logic [4:0] OP_L1       = 5'd15;
  localparam logic [4:0] OP_L2       = 5'd16;
  localparam logic [4:0] OP_L3       = 5'd17;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_MAX, S_SHIFT, S_CHK, S_DIV, S_NEXT, S_OUT
  } state_e;

  state_e              st_q;
  logic [4:0]          op_q;
  logic                line_q;
  item_t               itm_q;
  logic signed [65:0]  prod_q;
  logic signed [63:0]  acc_q;
  logic signed [63:0]  lc_q [3];
  logic [63:0]         mx_q;
  logic [55:0]         nrm_q;
  logic [52:0]         dmag_q;
  logic [109:0]        sq_q;
  logic [47:0]         t2_q;
  logic [109:0]        lim_q;
  logic [64:0]         rem_q;
  logic [31:0]         quo_q;
  logic [4:0]          bit_q;
  logic [31:0]         err_q, e0_q;
  logic                ok_q, ok0_q;
  logic [16:0]         tally_q;
  logic                out_vld_q;
  logic [31:0]         out_err_q;
  logic                out_good_q;

  logic signed [32:0]  opa, opb;
  logic [1:0]          row;
  logic                sel_j;
  logic [3:0]          fidx_ab, fidx_c, row4;
  logic signed [31:0]  f_ab, f_c;
  logic signed [23:0]  cu, cv, px, py;
  logic signed [27:0]  ca, cb;
  logic [63:0]         p64;
  logic [109:0]        pz;
  logic signed [63:0]  dsum;
  logic [63:0]         abs0, abs1, abs2, mx_d;
  logic [63:0]         den;
  logic [64:0]         rem_sh;
  logic [31:0]         sq_lo;
  logic                ge;
  logic [31:0]         err_fin;
  logic                good_fin;
  logic [16:0]         tally_base, tally_d;

  // Line coordinates come from one point, the distance from the other
  assign cu = line_q ? itm_q.x2 : itm_q.x1;
  assign cv = line_q ? itm_q.y2 : itm_q.y1;
  assign px = line_q ? itm_q.x1 : itm_q.x2;
  assign py = line_q ? itm_q.y1 : itm_q.y2;

  // Matrix entry selection: rows of F for the first line, columns for the second
  assign row   = op_q[2:1];
  assign sel_j = op_q[0];
  assign row4  = {2'b00, row};
  always_comb begin
    if (line_q) begin
      fidx_ab = row4 + (sel_j ? 4'd3 : 4'd0);
      fidx_c  = row4 + 4'd6;
    end else begin
      fidx_ab = (row4 << 1) + row4 + {3'b000, sel_j};
      fidx_c  = (row4 << 1) + row4 + 4'd2;
    end
  end
  assign f_ab = coef_i[fidx_ab];
  assign f_c  = coef_i[fidx_c];

  // Reduced line terms after normalization
  assign ca = lc_q[0][27:0];
  assign cb = lc_q[1][27:0];

  // Operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_q) inside
      [OP_ROW0:OP_ROW_LAST]: begin
        opa = {f_ab[31], f_ab};
        opb = sel_j ? {{9{cv[23]}}, cv} : {{9{cu[23]}}, cu};
      end
      OP_NA: begin opa = {{5{ca[27]}}, ca}; opb = {{5{ca[27]}}, ca}; end
      OP_NB: begin opa = {{5{cb[27]}}, cb}; opb = {{5{cb[27]}}, cb}; end
      OP_DX: begin opa = {{9{px[23]}}, px}; opb = {{5{ca[27]}}, ca}; end
      OP_DY: begin opa = {{9{py[23]}}, py}; opb = {{5{cb[27]}}, cb}; end
      OP_SQ0: begin opa = {6'b0, dmag_q[26:0]}; opb = {6'b0, dmag_q[26:0]}; end
      OP_SQ1: begin opa = {7'b0, dmag_q[52:27]}; opb = {6'b0, dmag_q[26:0]}; end
      OP_SQ2: begin opa = {7'b0, dmag_q[52:27]}; opb = {7'b0, dmag_q[52:27]}; end
      OP_TT:  begin opa = {9'b0, limit_i}; opb = {9'b0, limit_i}; end
      OP_L0:  begin opa = {9'b0, t2_q[23:0]}; opb = {5'b0, nrm_q[27:0]}; end
      OP_L1:  begin opa = {9'b0, t2_q[23:0]}; opb = {5'b0, nrm_q[55:28]}; end
      OP_L2:  begin opa = {9'b0, t2_q[47:24]}; opb = {5'b0, nrm_q[27:0]}; end
      OP_L3:  begin opa = {9'b0, t2_q[47:24]}; opb = {5'b0, nrm_q[55:28]}; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Product views and helper terms
  assign p64  = prod_q[63:0];
  assign pz   = {44'b0, prod_q};
  assign dsum = acc_q + $signed(p64);
  assign abs0 = lc_q[0][63] ? 64'(-lc_q[0]) : 64'(lc_q[0]);
  assign abs1 = lc_q[1][63] ? 64'(-lc_q[1]) : 64'(lc_q[1]);
  assign abs2 = lc_q[2][63] ? 64'(-lc_q[2]) : 64'(lc_q[2]);
  always_comb begin
    mx_d = abs0;
    if (abs1 > mx_d) mx_d = abs1;
    if (abs2 > mx_d) mx_d = abs2;
  end

  // Restoring divide step
  assign den    = {nrm_q, 8'b0};
  assign sq_lo  = sq_q[31:0];
  assign rem_sh = {rem_q[63:0], sq_lo[bit_q]};
  assign ge     = (rem_sh >= {1'b0, den});

  // Final combine of the two distances and the running count
  assign err_fin    = (err_q > e0_q) ? err_q : e0_q;
  assign good_fin   = ok_q && ok0_q;
  assign tally_base = itm_q.start ? 17'd0 : tally_q;
  assign tally_d    = (good_fin && (tally_base < 17'(CAP))) ? tally_base + 17'd1 : tally_base;

  assign item_pop_o   = (st_q == S_IDLE) && item_valid_i;
  assign out_valid_o  = out_vld_q;
  assign error_o      = out_err_q;
  assign inlier_o     = out_good_q;
  assign good_count_o = tally_q;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    case (st_q)
      S_IDLE: begin
        if (item_valid_i) itm_q <= item_i;
      end
      S_ACC: begin
        case (op_q) inside
          [OP_ROW0:OP_ROW_LAST]: begin
            if (!sel_j) acc_q <= {{24{f_c[31]}}, f_c, 8'b0} + $signed(p64);
            else        lc_q[row] <= dsum;
          end
          OP_NA:  acc_q <= $signed(p64);
          OP_NB:  nrm_q <= dsum[55:0];
          OP_DX:  acc_q <= {lc_q[2][55:0], 8'b0} + $signed(p64);
          OP_DY:  dmag_q <= dsum[63] ? 53'(-dsum) : dsum[52:0];
          OP_SQ0: sq_q <= pz;
          OP_SQ1: sq_q <= sq_q + (pz << 28);
          OP_SQ2: sq_q <= sq_q + (pz << 54);
          OP_TT:  t2_q <= prod_q[47:0];
          OP_L0:  lim_q <= pz;
          OP_L1:  lim_q <= lim_q + (pz << 28);
          OP_L2:  lim_q <= lim_q + (pz << 24);
          OP_L3:  lim_q <= lim_q + (pz << 52);
          default: acc_q <= acc_q;
        endcase
      end
      S_MAX: mx_q <= mx_d;
      S_SHIFT: begin
        if (mx_q[63:27] != '0) begin
          mx_q    <= mx_q >> 1;
          lc_q[0] <= lc_q[0] >>> 1;
          lc_q[1] <= lc_q[1] >>> 1;
          lc_q[2] <= lc_q[2] >>> 1;
        end
      end
      S_CHK: begin
        rem_q <= {1'b0, sq_q[95:32]};
        quo_q <= '0;
        bit_q <= 5'd31;
        if (nrm_q == '0) begin
          err_q <= ERR_SAT;
          ok_q  <= 1'b0;
        end else begin
          ok_q <= (sq_q <= lim_q);
          if ({14'b0, den, 32'b0} <= sq_q) err_q <= ERR_SAT;
        end
      end
      S_DIV: begin
        rem_q <= ge ? rem_sh - {1'b0, den} : rem_sh;
        quo_q <= {quo_q[30:0], ge};
        bit_q <= bit_q - 5'd1;
        if (bit_q == 5'd0) err_q <= {quo_q[30:0], ge};
      end
      S_NEXT: begin
        if (!line_q) begin
          e0_q  <= err_q;
          ok0_q <= ok_q;
        end
      end
      S_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_err_q  <= err_fin;
          out_good_q <= good_fin;
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  // Sequencer, running count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      op_q      <= OP_ROW0;
      line_q    <= 1'b0;
      tally_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && !out_stall_i && (st_q != S_OUT)) out_vld_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (item_valid_i) begin
            line_q <= 1'b0;
            op_q   <= OP_ROW0;
            st_q   <= S_MUL;
          end
        end
        S_MUL: st_q <= S_ACC;
        S_ACC: begin
          if (op_q == OP_ROW_LAST) begin
            st_q <= S_MAX;
          end else if (op_q == OP_L3) begin
            st_q <= S_CHK;
          end else begin
            op_q <= op_q + 5'd1;
            st_q <= S_MUL;
          end
        end
        S_MAX: st_q <= S_SHIFT;
        S_SHIFT: begin
          if (mx_q[63:27] == '0) begin
            op_q <= OP_NA;
            st_q <= S_MUL;
          end
        end
        S_CHK: begin
          if (nrm_q == '0 || ({14'b0, den, 32'b0} <= sq_q)) st_q <= S_NEXT;
          else st_q <= S_DIV;
        end
        S_DIV: begin
          if (bit_q == 5'd0) st_q <= S_NEXT;
        end
        S_NEXT: begin
          if (!line_q) begin
            line_q <= 1'b1;
            op_q   <= OP_ROW0;
            st_q   <= S_MUL;
          end else begin
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q <= 1'b1;
            tally_q   <= tally_d;
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/epipolar_inlier_classifier.sv -----
// The back end handles one item at a time with the shared 33x33 multiplier and
// the radix-2 divider; each line's normalization shift is 0 to 29, and a
// saturated or zero-normal line skips its divide. A two-entry input queue
// takes items while the back end works.
// Reset (rst_ni low, asynchronous) clears config registers, queue, count and valids.
module epipolar_inlier_classifier #(
  parameter int MAX_POINTS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] first_x_i,
  input  logic signed [23:0] first_y_i,
  input  logic signed [23:0] second_x_i,
  input  logic signed [23:0] second_y_i,
  input  logic               start_set_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        error_o,
  output logic               inlier_o,
  output logic [16:0]        good_count_o
);
  import eic_pkg::*;

  coef_t       coef_q;
  logic [23:0] limit_q;
  item_t       item;
  logic        item_valid, item_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAIR_A: begin coef_q[0] <= cfg_data_i[63:32]; coef_q[1] <= cfg_data_i[31:0]; end
        CFG_PAIR_B: begin coef_q[2] <= cfg_data_i[63:32]; coef_q[3] <= cfg_data_i[31:0]; end
        CFG_PAIR_C: begin coef_q[4] <= cfg_data_i[63:32]; coef_q[5] <= cfg_data_i[31:0]; end
        CFG_PAIR_D: begin coef_q[6] <= cfg_data_i[63:32]; coef_q[7] <= cfg_data_i[31:0]; end
        CFG_FINAL:  coef_q[8] <= cfg_data_i[31:0];
        CFG_LIMIT:  limit_q   <= cfg_data_i[23:0];
        default:    limit_q   <= limit_q;
      endcase
    end
  end

  // Front end: input transfer and queue
  eic_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .start_set_i  (start_set_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back end: distance computation, count and output register
  eic_engine #(
    .MAX_POINTS (MAX_POINTS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .coef_i       (coef_q),
    .limit_i      (limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .error_o      (error_o),
    .inlier_o     (inlier_o),
    .good_count_o (good_count_o)
  );

endmodule

// ----- tb/epipolar_inlier_classifier_tb.sv -----
`timescale 1ns / 1ps

module epipolar_inlier_classifier_tb;
  import eic_pkg::*;

  localparam int  MAX_PTS   = 65536;
  localparam int  TALLY_CAP = (MAX_PTS > 131071) ? 131071 : MAX_PTS;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  DRAIN_CYCLES = 400;

  typedef struct {
    logic [31:0] error;
    logic        inlier;
    logic [16:0] good_count;
  } verdict_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] first_x_i = '0;
  logic signed [23:0] first_y_i = '0;
  logic signed [23:0] second_x_i = '0;
  logic signed [23:0] second_y_i = '0;
  logic               start_set_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        error_o;
  logic               inlier_o;
  logic [16:0]        good_count_o;

  epipolar_inlier_classifier #(.MAX_POINTS(MAX_PTS)) u_top (.*);

  // Shadow of the block's configuration and count
  logic signed [31:0] fmat [9];
  logic [23:0]        dist_limit;
  logic [16:0]        tally;

  item_t    pair_q [$];
  verdict_t verdict_q [$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       failed = 1'b0;
  bit       hold_send = 1'b0;
  longint   cycle_cnt = 0;

  initial forever #1 clk_i = ~clk_i;

  // Floor shift of a signed value
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // Squared distance of point (px,py) from line a*x+b*y+c, plus threshold pass
  function automatic logic [31:0] line_dist(longint la, longint lb, longint lc,
                                            longint px, longint py,
                                            logic [63:0] t2, output bit pass);
    longint       m, a, b, c;
    int           s;
    logic [63:0]  n;
    logic signed [127:0] d;
    logic [127:0] sq, quo;
    m = (la < 0) ? -la : la;
    if (((lb < 0) ? -lb : lb) > m) m = (lb < 0) ? -lb : lb;
    if (((lc < 0) ? -lc : lc) > m) m = (lc < 0) ? -lc : lc;
    s = 0;
    while ((m >>> s) >= (64'sd1 <<< 27)) s++;
    a = fshift(la, s);
    b = fshift(lb, s);
    c = fshift(lc, s);
    n = a * a + b * b;
    if (n == 0) begin
      pass = 1'b0;
      return ERR_SAT;
    end
    d = 128'(px) * a + 128'(py) * b + 128'(c) * 256;
    if (d < 0) d = -d;
    sq = d * d;
    pass = (sq <= 128'(t2) * 128'(n));
    quo = sq / (128'(n) << 8);
    return (quo > 128'(ERR_SAT)) ? ERR_SAT : quo[31:0];
  endfunction

  // Expected verdict for one correspondence; updates the tally
  function automatic verdict_t classify_pair(item_t it);
    longint   f [9];
    longint   x1, y1, x2, y2;
    logic [31:0] e1, e2;
    bit       ok1, ok2;
    logic [63:0] t2;
    verdict_t v;
    for (int i = 0; i < 9; i++) f[i] = fmat[i];
    x1 = it.x1; y1 = it.y1; x2 = it.x2; y2 = it.y2;
    t2 = 64'(dist_limit) * 64'(dist_limit);
    e2 = line_dist(f[0] * x1 + f[1] * y1 + f[2] * 256, f[3] * x1 + f[4] * y1 + f[5] * 256,
                   f[6] * x1 + f[7] * y1 + f[8] * 256, x2, y2, t2, ok2);
    e1 = line_dist(f[0] * x2 + f[3] * y2 + f[6] * 256, f[1] * x2 + f[4] * y2 + f[7] * 256,
                   f[2] * x2 + f[5] * y2 + f[8] * 256, x1, y1, t2, ok1);
    if (it.start) tally = '0;
    if (tally > TALLY_CAP) tally = TALLY_CAP;
    if (ok1 && ok2 && tally < TALLY_CAP) tally++;
    v.error = (e1 > e2) ? e1 : e2;
    v.inlier = ok1 && ok2;
    v.good_count = tally;
    return v;
  endfunction

  // Driver: takes pairs from the pending queue, predicts on each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.insert(verdict_q.size(), classify_pair(pair_q.pop_front()));
      end
      if ((!in_valid_i || !in_stall_o) && !cfg_we_i) begin
        if ((in_valid_i && !in_stall_o ? pair_q.size() > 0 : pair_q.size() > 0) &&
            !hold_send && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          first_x_i   <= pair_q[0].x1;
          first_y_i   <= pair_q[0].y1;
          second_x_i  <= pair_q[0].x2;
          second_y_i  <= pair_q[0].y2;
          start_set_i <= pair_q[0].start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compares every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: error %h inlier %b good_count %0d",
               error_o, inlier_o, good_count_o);
        failed = 1'b1;
      end else begin
        verdict_t exp_v;
        exp_v = verdict_q.pop_front();
        if (error_o !== exp_v.error) begin
          $error("error: expected %h, got %h", exp_v.error, error_o);
          failed = 1'b1;
        end
        if (inlier_o !== exp_v.inlier) begin
          $error("inlier: expected %b, got %b", exp_v.inlier, inlier_o);
          failed = 1'b1;
        end
        if (good_count_o !== exp_v.good_count) begin
          $error("good_count: expected %0d, got %0d", exp_v.good_count, good_count_o);
          failed = 1'b1;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[epipolar_inlier_classifier] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pair_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_PAIR_A: begin fmat[0] = val[63:32]; fmat[1] = val[31:0]; end
      CFG_PAIR_B: begin fmat[2] = val[63:32]; fmat[3] = val[31:0]; end
      CFG_PAIR_C: begin fmat[4] = val[63:32]; fmat[5] = val[31:0]; end
      CFG_PAIR_D: begin fmat[6] = val[63:32]; fmat[7] = val[31:0]; end
      CFG_FINAL:  fmat[8] = val[31:0];
      CFG_LIMIT:  dist_limit = val[23:0];
      default: ;
    endcase
  endtask

  // Matrix either random, at the extremes, or small values scaled by a random shift
  task automatic load_matrix(int style, logic [23:0] lim);
    logic [31:0] e [9];
    for (int i = 0; i < 9; i++) begin
      case (style)
        0: e[i] = $urandom;
        1: e[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        2: e[i] = 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(20);
        default: e[i] = '0;
      endcase
    end
    write_reg(CFG_PAIR_A, {e[0], e[1]});
    write_reg(CFG_PAIR_B, {e[2], e[3]});
    write_reg(CFG_PAIR_C, {e[4], e[5]});
    write_reg(CFG_PAIR_D, {e[6], e[7]});
    write_reg(CFG_FINAL, {32'h0, e[8]});
    write_reg(CFG_LIMIT, {40'h0, lim});
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(5))
      0: return 24'h80_0000;
      1: return 24'h7F_FFFF;
      2: return 24'($signed($urandom_range(1024)) - 512);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_pair(logic [23:0] a, logic [23:0] b, logic [23:0] c, logic [23:0] d,
                          logic st);
    item_t it;
    it.x1 = a; it.y1 = b; it.x2 = c; it.y2 = d; it.start = st;
    pair_q.insert(pair_q.size(), it);
  endtask

  initial begin
    for (int i = 0; i < 9; i++) fmat[i] = '0;
    dist_limit = '0;
    tally = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero matrix: zero normal on both lines
    add_pair(24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
    add_pair(24'h7F_FFFF, 24'h80_0000, 24'h1, 24'hFF_FFFF, 1'b0);
    wait_drained();

    // Pure translation x: rows give finite lines; then extremes
    write_reg(CFG_PAIR_B, {32'h0, 32'h0});
    write_reg(CFG_PAIR_C, {32'h0, 32'hC000_0000});
    write_reg(CFG_PAIR_D, {32'h0, 32'h4000_0000});
    write_reg(CFG_LIMIT, {40'h0, 24'hFF_FFFF});
    add_pair(24'h100, 24'h200, 24'h300, 24'h200, 1'b1);
    add_pair(24'h100, 24'h200, 24'h300, 24'h7F_FFFF, 1'b0);
    add_pair(24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 1'b0);
    add_pair(24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 1'b1);
    wait_drained();
    load_matrix(1, 24'h0);
    for (int i = 0; i < 12; i++)
      add_pair(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), i[2]);
    wait_drained();

    // Random phases across idle patterns and settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin send_idle_pct = 34; recv_idle_pct = 88; end
      if (ph == 4) begin send_idle_pct = 88; recv_idle_pct = 34; end
      if (ph == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      load_matrix(ph % 3, (ph == 5) ? 24'hFF_FFFF : (ph == 9) ? 24'h0 : 24'($urandom));
      for (int i = 0; i < 165; i++)
        add_pair(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 $urandom_range(49) == 0);
      if (ph == 10) begin
        // hold the sender until every result is back
        while (pair_q.size() > 80) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_valid_i || verdict_q.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    if (!failed) begin
      $display("[epipolar_inlier_classifier] OK");
    end else begin
      $display("[epipolar_inlier_classifier] ERROR");
    end
    $finish;
  end

endmodule
